// ===== design/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants of the per-protocol traffic meter
// Field widths, protocol and frame-type codes, register indexes, the record
// that travels from the classifier to the counting engine, and the engine's
// state type.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int MAC_W      = 48;
    localparam int ETYPE_W    = 16;
    localparam int PROTO_W    = 8;
    localparam int LEN_W      = 16;
    localparam int TS_W       = 32;
    localparam int WIN_W      = 31;
    localparam int CNT_OUT_W  = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    // Slot 0 is the total, then one slot per reported protocol.
    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0]   LINK_HDR_LEN  = 16'd14;
    localparam logic [ETYPE_W-1:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [ETYPE_W-1:0] ETYPE_HI_MASK = 16'hFF00;
    localparam logic [ETYPE_W-1:0] ETYPE_IP_ALT  = 16'h1000;

    localparam logic [PROTO_W-1:0] PROTO_TOTAL = 8'd0;
    localparam logic [PROTO_W-1:0] PROTO_IPIP  = 8'd4;
    localparam logic [PROTO_W-1:0] PROTO_UDP   = 8'd17;
    localparam logic [PROTO_W-1:0] PROTO_TCP   = 8'd6;

    localparam logic [WIN_W-1:0] WINDOW_MS_RESET = 31'd300000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_MAC = 8'd0,
        CFG_WINDOW_MS  = 8'd1
    } cfg_index_t;

    typedef enum logic {
        BK_RUN,
        BK_REPORT
    } back_state_t;

    // One classified frame: which directions it counts in, its extra slot
    // (zero when only the total applies), its clamped length and its time.
    typedef struct packed {
        logic              count_in;
        logic              count_out;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [TS_W-1:0]   ts;
    } ppm_rec_t;

    function automatic logic [PROTO_W-1:0] slot_proto(input logic [SLOT_W-1:0] slot);
        logic [PROTO_W-1:0] p;
        unique case (slot)
            2'd0:    p = PROTO_TOTAL;
            2'd1:    p = PROTO_IPIP;
            2'd2:    p = PROTO_UDP;
            default: p = PROTO_TCP;
        endcase
        return p;
    endfunction

endpackage

// ===== design/ppm_in_if.sv =====
// ----------------------------------------------------------------------------
// ppm_in_if: frame header channel
// Valid/ready channel that carries one captured frame header per transfer.
// ----------------------------------------------------------------------------
interface ppm_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] ether_type;
    logic [7:0]  ip_proto;
    logic [15:0] ip_total_length;
    logic [15:0] capture_length;
    logic [31:0] timestamp_ms;

    modport source (
        output valid, src_mac, dst_mac, ether_type, ip_proto, ip_total_length,
               capture_length, timestamp_ms,
        input  ready
    );
    modport sink (
        input  valid, src_mac, dst_mac, ether_type, ip_proto, ip_total_length,
               capture_length, timestamp_ms,
        output ready
    );
endinterface

// ===== design/ppm_out_if.sv =====
// ----------------------------------------------------------------------------
// ppm_out_if: report line channel
// Valid/ready channel that carries one report line per transfer.
// ----------------------------------------------------------------------------
interface ppm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_ms;
    logic [7:0]  proto_number;
    logic [31:0] packets_in;
    logic [31:0] bytes_in;
    logic [31:0] packets_out;
    logic [31:0] bytes_out;
    logic        last_of_report;

    modport source (
        output valid, elapsed_ms, proto_number, packets_in, bytes_in, packets_out,
               bytes_out, last_of_report,
        input  ready
    );
    modport sink (
        input  valid, elapsed_ms, proto_number, packets_in, bytes_in, packets_out,
               bytes_out, last_of_report,
        output ready
    );
endinterface

// ===== design/ppm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ppm_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface ppm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [47:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== design/ppm_front.sv =====
// ----------------------------------------------------------------------------
// ppm_front: frame classifier
// Drops short captures, recognizes IP frame types, clamps the IP length to
// the captured payload, matches both addresses and picks the protocol slot.
// ----------------------------------------------------------------------------
module ppm_front
    import ppm_pkg::*;
(
    ppm_in_if.sink           frame,
    input  logic [MAC_W-1:0] target_mac,
    input  logic             q_ready,
    output logic             q_push,
    output ppm_rec_t         q_rec
);

    logic             long_enough;
    logic             is_ip;
    logic [LEN_W-1:0] room;

    assign frame.ready = q_ready;
    assign long_enough = frame.capture_length >= LINK_HDR_LEN;
    assign room        = frame.capture_length - LINK_HDR_LEN;
    assign is_ip       = (frame.ether_type == ETYPE_IPV4)
                      || ((frame.ether_type & ETYPE_HI_MASK) == ETYPE_IP_ALT);

    // Short captures vanish here: they neither latch the window nor report.
    assign q_push = frame.valid && q_ready && long_enough;

    always_comb
    begin
        q_rec.count_in  = is_ip && (frame.src_mac == target_mac);
        q_rec.count_out = is_ip && (frame.dst_mac == target_mac);
        q_rec.len       = (frame.ip_total_length > room) ? room : frame.ip_total_length;
        q_rec.ts        = frame.timestamp_ms;
        case (frame.ip_proto)
            PROTO_IPIP: q_rec.slot = SLOT_W'(1);
            PROTO_UDP:  q_rec.slot = SLOT_W'(2);
            PROTO_TCP:  q_rec.slot = SLOT_W'(3);
            default:    q_rec.slot = '0;
        endcase
    end

endmodule

// ===== design/ppm_queue.sv =====
// ----------------------------------------------------------------------------
// ppm_queue: record queue
// Short first-in first-out buffer of classified records between the
// classifier and the counting engine.
// ----------------------------------------------------------------------------
module ppm_queue
    import ppm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ppm_rec_t push_rec,
    output logic     not_full,
    input  logic     pop,
    output logic     not_empty,
    output ppm_rec_t head_rec
);

    ppm_rec_t            store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign not_full  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_rec  = store_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("record queue holds more than its depth");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("record queue pointers disagree with its fill count");

endmodule

// ===== design/ppm_back.sv =====
// ----------------------------------------------------------------------------
// ppm_back: counting engine and report sequencer
// Latches the window start, bumps the per-slot counters, and when the window
// has run out sends four report lines through an output register and clears.
// ----------------------------------------------------------------------------
module ppm_back
    import ppm_pkg::*;
#(
    parameter int CNT_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rec_valid,
    input  ppm_rec_t         rec,
    output logic             rec_pop,
    input  logic [WIN_W-1:0] window_ms,
    ppm_out_if.source        report
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [SLOT_W-1:0]  line_reg;
    logic [SLOT_W-1:0]  line_next;
    logic [TS_W-1:0]    start_reg;
    logic [TS_W-1:0]    start_next;
    logic [TS_W-1:0]    elapsed_reg;
    logic [CNT_W-1:0]   in_pk_reg   [SLOTS];
    logic [CNT_W-1:0]   in_by_reg   [SLOTS];
    logic [CNT_W-1:0]   out_pk_reg  [SLOTS];
    logic [CNT_W-1:0]   out_by_reg  [SLOTS];
    logic [CNT_W-1:0]   in_pk_next  [SLOTS];
    logic [CNT_W-1:0]   in_by_next  [SLOTS];
    logic [CNT_W-1:0]   out_pk_next [SLOTS];
    logic [CNT_W-1:0]   out_by_next [SLOTS];

    logic               out_valid_reg;
    logic [TS_W-1:0]    out_elapsed_reg;
    logic [PROTO_W-1:0] out_proto_reg;
    logic [CNT_OUT_W-1:0] out_in_pk_reg;
    logic [CNT_OUT_W-1:0] out_in_by_reg;
    logic [CNT_OUT_W-1:0] out_out_pk_reg;
    logic [CNT_OUT_W-1:0] out_out_by_reg;
    logic               out_last_reg;

    logic               take_rec;
    logic               load_line;
    logic               last_line;
    logic               clear_all;
    logic [TS_W-1:0]    start_eff;
    logic [TS_W-1:0]    elapsed;
    logic               window_done;

    // A start of zero means unset, so the current frame's time stands in.
    assign start_eff   = (start_reg == '0) ? rec.ts : start_reg;
    assign elapsed     = rec.ts - start_eff;
    assign window_done = elapsed >= {1'b0, window_ms};
    assign last_line   = line_reg == SLOT_W'(SLOTS - 1);

    // State machine outputs.
    always_comb
    begin
        rec_pop   = 1'b0;
        load_line = 1'b0;
        unique case (state_reg)
            BK_RUN:
            begin
                rec_pop = rec_valid;
            end
            BK_REPORT:
            begin
                load_line = !out_valid_reg || report.ready;
            end
            default:
            begin
                rec_pop = 1'b0;
            end
        endcase
    end

    assign take_rec  = rec_pop;
    assign clear_all = load_line && last_line;

    // State machine next state.
    always_comb
    begin
        state_next = state_reg;
        line_next  = line_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                line_next = '0;
                if (take_rec && window_done)
                begin
                    state_next = BK_REPORT;
                end
            end
            BK_REPORT:
            begin
                if (load_line)
                begin
                    line_next = line_reg + 1'b1;
                    if (last_line)
                    begin
                        state_next = BK_RUN;
                    end
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        start_next = start_reg;
        if (take_rec)
        begin
            start_next = start_eff;
        end
        if (clear_all)
        begin
            start_next = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            in_pk_next[i]  = in_pk_reg[i];
            in_by_next[i]  = in_by_reg[i];
            out_pk_next[i] = out_pk_reg[i];
            out_by_next[i] = out_by_reg[i];
            if (take_rec && (i == 0 || rec.slot == SLOT_W'(i)))
            begin
                if (rec.count_in)
                begin
                    in_pk_next[i] = in_pk_reg[i] + CNT_W'(1);
                    in_by_next[i] = in_by_reg[i] + CNT_W'(rec.len);
                end
                if (rec.count_out)
                begin
                    out_pk_next[i] = out_pk_reg[i] + CNT_W'(1);
                    out_by_next[i] = out_by_reg[i] + CNT_W'(rec.len);
                end
            end
            if (clear_all)
            begin
                in_pk_next[i]  = '0;
                in_by_next[i]  = '0;
                out_pk_next[i] = '0;
                out_by_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            line_reg      <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                in_pk_reg[i]  <= '0;
                in_by_reg[i]  <= '0;
                out_pk_reg[i] <= '0;
                out_by_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            if (load_line)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                in_pk_reg[i]  <= in_pk_next[i];
                in_by_reg[i]  <= in_by_next[i];
                out_pk_reg[i] <= out_pk_next[i];
                out_by_reg[i] <= out_by_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_rec && window_done)
        begin
            elapsed_reg <= elapsed;
        end
        if (load_line)
        begin
            out_elapsed_reg <= elapsed_reg;
            out_proto_reg   <= slot_proto(line_reg);
            out_in_pk_reg   <= CNT_OUT_W'(in_pk_reg[line_reg]);
            out_in_by_reg   <= CNT_OUT_W'(in_by_reg[line_reg]);
            out_out_pk_reg  <= CNT_OUT_W'(out_pk_reg[line_reg]);
            out_out_by_reg  <= CNT_OUT_W'(out_by_reg[line_reg]);
            out_last_reg    <= last_line;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.elapsed_ms     = out_elapsed_reg;
    assign report.proto_number   = out_proto_reg;
    assign report.packets_in     = out_in_pk_reg;
    assign report.bytes_in       = out_in_by_reg;
    assign report.packets_out    = out_out_pk_reg;
    assign report.bytes_out      = out_out_by_reg;
    assign report.last_of_report = out_last_reg;

    a_clear_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        clear_all |=> (start_reg == '0 && in_pk_reg[0] == '0 && out_pk_reg[0] == '0))
        else $error("state not cleared after the last report line");

    a_last_is_tcp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_proto_reg == PROTO_TCP)
        else $error("final report line carries the wrong protocol");

    a_idle_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_RUN |-> (line_reg == '0 && !load_line))
        else $error("report sequencer active outside a report");

    a_report_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (take_rec && window_done) |=> (state_reg == BK_REPORT && !rec_pop))
        else $error("record taken while a report is pending");

endmodule

// ===== design/per_protocol_traffic_meter_top.sv =====
// ----------------------------------------------------------------------------
// per_protocol_traffic_meter_top: per-protocol traffic meter
// Counts the IP packets and bytes one station sends and receives, in total and
// for protocols 4, 17 and 6, and reports them once per time window.
// ----------------------------------------------------------------------------
// Throughput: one frame header per cycle while the record queue has room; a frame
//   closing a window holds the engine for four report lines (longer under output
//   backpressure), while the two-entry queue takes two frames and the input stalls.
// Report path: record queue, engine state register, report output register; then one
//   line per cycle while the sink is ready.
// Reset: asynchronous rst_n clears counters and window start, target_mac to 0 and
//   window_ms to 300000. No clearing pass is needed.
module per_protocol_traffic_meter_top
    import ppm_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    ppm_in_if.sink    frame,
    ppm_out_if.source report,
    ppm_cfg_if.sink   cfg
);

    // Configuration registers. The block never refuses a write; the user must issue
    // writes only while no frame is in flight; the block does not enforce this.
    logic [MAC_W-1:0] target_mac_reg;
    logic [MAC_W-1:0] target_mac_next;
    logic [WIN_W-1:0] window_ms_reg;
    logic [WIN_W-1:0] window_ms_next;
    logic             cfg_write;

    // Front-to-back record path.
    logic     q_push;
    ppm_rec_t q_push_rec;
    logic     q_not_full;
    logic     q_pop;
    logic     q_not_empty;
    ppm_rec_t q_head_rec;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Writes to an index beyond the register list are accepted and dropped.
    always_comb
    begin
        target_mac_next = target_mac_reg;
        window_ms_next  = window_ms_reg;
        if (cfg_write)
        begin
            unique case (cfg.index)
                CFG_TARGET_MAC: target_mac_next = cfg.data[MAC_W-1:0];
                CFG_WINDOW_MS:  window_ms_next  = cfg.data[WIN_W-1:0];
                default:        target_mac_next = target_mac_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_mac_reg <= '0;
            window_ms_reg  <= WINDOW_MS_RESET;
        end
        else
        begin
            target_mac_reg <= target_mac_next;
            window_ms_reg  <= window_ms_next;
        end
    end

    // The classifier turns each accepted header into a compact record. Frames
    // with a capture shorter than the link header never enter the queue.
    ppm_front u_front (
        .frame      (frame),
        .target_mac (target_mac_reg),
        .q_ready    (q_not_full),
        .q_push     (q_push),
        .q_rec      (q_push_rec)
    );

    // The queue lets the classifier keep accepting transfers, until it is full,
    // while the counting engine is busy sending a report.
    ppm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (q_push_rec),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_rec  (q_head_rec)
    );

    // The counting engine owns all metering state and the report output
    // register; the result side stalls the engine, and the classifier once the queue is full.
    ppm_back #(
        .CNT_W (COUNTER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_not_empty),
        .rec       (q_head_rec),
        .rec_pop   (q_pop),
        .window_ms (window_ms_reg),
        .report    (report)
    );

endmodule
